FILE: rtl/ptev_pkg.sv
// Package: shared types, constants and op codes for the peer table block
package ptev_pkg;

    localparam int TableSizeDefault = 64;
    localparam int KeyW = 32;
    localparam int TimeW = 48;
    localparam int CountW = 32;
    localparam int SlotW = 6;

    localparam logic [1:0] ST_ACTIVE  = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_GONE    = 2'd2;

    typedef enum logic [2:0] {
        OP_UP      = 3'd0,
        OP_INTEREST = 3'd1,
        OP_DOWN    = 3'd2,
        OP_BEGIN   = 3'd3,
        OP_REFRESH = 3'd4,
        OP_END     = 3'd5,
        OP_READ    = 3'd6,
        OP_NONE    = 3'd7
    } op_t;

    typedef struct packed {
        logic [2:0]       op;
        logic [KeyW-1:0]  peer_key;
        logic [TimeW-1:0] now_ms;
        logic             peer_is_dropped;
        logic [5:0]       read_index;
    } item_t;

    typedef struct packed {
        logic [SlotW-1:0]  slot_index;
        logic              hit;
        logic              slot_used;
        logic [KeyW-1:0]   slot_key;
        logic [1:0]        peer_state;
        logic [CountW-1:0] update_count;
        logic [TimeW-1:0]  alloc_time;
        logic [TimeW-1:0]  touch_time;
        logic [TimeW-1:0]  down_time;
    } result_t;

    // One stored record in the record RAM (valid and seen live in flops)
    typedef struct packed {
        logic [KeyW-1:0]   key;
        logic [1:0]        status;
        logic [CountW-1:0] count;
        logic [TimeW-1:0]  first;
        logic [TimeW-1:0]  last;
        logic [TimeW-1:0]  down;
    } rec_t;

    localparam int RecW = $bits(rec_t);

    // Controller to datapath commands
    typedef struct packed {
        logic clr_scan;    // reset scan index and search results
        logic scan_step;   // evaluate RAM output of current index, advance
        logic rd_issue;    // issue RAM read at the next scan index (slot 0 on clear)
        logic rd_cur;      // issue RAM read at the current scan index
        logic rd_sel;      // issue RAM read at chosen slot (at the read index for a read)
        logic clr_seen;    // clear all seen marks
        logic write_rec;   // write updated record to chosen slot
        logic end_step;    // apply gone marking to RAM output of scan index
        logic emit;        // present result
        logic emit_zero;   // present all-zero result
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;   // the scan index is the last slot
        logic found;       // lookup hit
    } stat_t;

endpackage

FILE: rtl/ptev_ram.sv
// Generic single-port RAM with registered read
module ptev_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // Write and read one address per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: rtl/ptev_ctrl.sv
// Controller state machine for the peer table block
module ptev_ctrl import ptev_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  [2:0] op,
    input  stat_t stat,
    output logic  busy,
    output cmd_t  cmd
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCAN  = 9'b000000010,
        S_RDSEL = 9'b000000100,
        S_WAIT  = 9'b000001000,
        S_WRITE = 9'b000010000,
        S_EMIT  = 9'b000100000,
        S_ENDSC = 9'b001000000,
        S_ZERO  = 9'b010000000,
        S_ENDRD = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_NONE;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Up/refresh: scan all slots, read chosen slot, write back, show result
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next = op;
                    cmd.clr_scan = 1'b1;
                    case (op)
                        OP_UP, OP_INTEREST, OP_DOWN, OP_REFRESH, OP_END:
                        begin
                            cmd.rd_issue = 1'b1;
                            state_next = (op == OP_END) ? S_ENDSC : S_SCAN;
                        end
                        OP_READ:
                        begin
                            state_next = S_RDSEL;
                        end
                        OP_BEGIN:
                        begin
                            cmd.clr_seen = 1'b1;
                            state_next = S_ZERO;
                        end
                        default:
                        begin
                            state_next = S_ZERO;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_RDSEL;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                end
            end
            S_RDSEL:
            begin
                cmd.rd_sel = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if ((op_reg == OP_INTEREST || op_reg == OP_DOWN) && !stat.found)
                begin
                    state_next = S_ZERO;
                end
                else if (op_reg == OP_READ)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write_rec = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                state_next = S_IDLE;
            end
            S_ENDSC:
            begin
                cmd.end_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_ZERO;
                end
                else
                begin
                    state_next = S_ENDRD;
                end
            end
            // Read the next slot once the RAM port is free of the mark write
            S_ENDRD:
            begin
                cmd.rd_cur = 1'b1;
                state_next = S_ENDSC;
            end
            S_ZERO:
            begin
                cmd.emit_zero = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

FILE: rtl/ptev_dp.sv
// Datapath: record RAM, valid and seen flops, scan and victim search
module ptev_dp import ptev_pkg::*; #(
    parameter int TableSize = TableSizeDefault
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  item_t   item,
    input  cmd_t    cmd,
    output stat_t   stat,
    output logic    done,
    output result_t res
);
    localparam int IdxW = (TableSize > 1) ? $clog2(TableSize) : 1;
    localparam int CntW = $clog2(TableSize + 1);

    logic [TableSize-1:0] valid_reg, seen_reg;
    item_t   item_reg;
    logic [IdxW-1:0] idx_reg;       // index whose RAM data arrives now
    logic [IdxW-1:0] sel_reg;
    logic found_reg, free_reg, gone_reg, drop_reg;
    logic [IdxW-1:0] hit_idx_reg, free_idx_reg, gone_idx_reg, drop_idx_reg;
    logic [TimeW-1:0] least_reg;
    logic    rd_in_range_reg;
    logic    ram_we;
    logic [IdxW-1:0] ram_addr;
    rec_t    ram_wdata, ram_q, upd;
    logic    done_reg;
    result_t res_reg;
    logic [IdxW-1:0] chosen;
    logic [IdxW-1:0] cur;

    ptev_ram #(.Width(RecW), .Depth(TableSize)) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_q)
    );

    assign cur = idx_reg;
    assign stat.scan_last = (CntW'(idx_reg) == CntW'(TableSize - 1));
    assign stat.found = found_reg;

    // Pick slot: hit, else first free, else least gone, else first dropped, else 0
    always_comb
    begin
        if (found_reg)      chosen = hit_idx_reg;
        else if (free_reg)  chosen = free_idx_reg;
        else if (gone_reg)  chosen = gone_idx_reg;
        else if (drop_reg)  chosen = drop_idx_reg;
        else                chosen = '0;
    end

    // Build the updated record from the chosen slot's stored data, or a fresh one for a new peer
    always_comb
    begin
        upd = ram_q;
        if (!found_reg)
        begin
            upd = '0;
            upd.key = item_reg.peer_key;
            upd.first = item_reg.now_ms;
        end
        case (item_reg.op)
            OP_UP:       upd.last = item_reg.now_ms;
            OP_INTEREST:
            begin
                upd.count = upd.count + CountW'(1);
                upd.last = item_reg.now_ms;
            end
            OP_DOWN:     upd.down = item_reg.now_ms;
            OP_REFRESH:  upd.status = item_reg.peer_is_dropped ? ST_DROPPED : ST_ACTIVE;
            default:     upd = upd;
        endcase
    end

    // RAM port: hold the selected slot on the read side unless a command moves it
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = upd;
        ram_addr  = sel_reg;
        if (cmd.rd_issue)
        begin
            ram_addr = (cmd.clr_scan) ? '0 : IdxW'(idx_reg + 1'b1);
        end
        else if (cmd.rd_cur)
        begin
            ram_addr = idx_reg;
        end
        else if (cmd.rd_sel)
        begin
            if (item_reg.op != OP_READ)
            begin
                ram_addr = chosen;
            end
        end
        else if (cmd.write_rec)
        begin
            ram_we   = 1'b1;
            ram_addr = sel_reg;
        end
        if (cmd.end_step && valid_reg[cur] && !seen_reg[cur] && ram_q.status != ST_GONE)
        begin
            ram_we    = 1'b1;
            ram_addr  = cur;
            ram_wdata = ram_q;
            ram_wdata.status = ST_GONE;
            if (ram_q.down == '0)
            begin
                ram_wdata.down = item_reg.now_ms;
            end
        end
    end

    // Control flops: valid, seen, scan results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            seen_reg  <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
            gone_reg  <= 1'b0;
            drop_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit || cmd.emit_zero;
            if (cmd.clr_scan)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
                gone_reg  <= 1'b0;
                drop_reg  <= 1'b0;
            end
            else if ((cmd.scan_step || cmd.end_step) && !stat.scan_last)
            begin
                idx_reg <= IdxW'(idx_reg + 1'b1);
            end
            if (cmd.scan_step)
            begin
                if (valid_reg[cur] && ram_q.key == item_reg.peer_key && !found_reg)
                begin
                    found_reg <= 1'b1;
                end
                if (!valid_reg[cur] && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
                if (valid_reg[cur] && ram_q.status == ST_GONE
                    && (!gone_reg || ram_q.down <= least_reg))
                begin
                    gone_reg <= 1'b1;
                end
                if (ram_q.status == ST_DROPPED && !drop_reg)
                begin
                    drop_reg <= 1'b1;
                end
            end
            if (cmd.clr_seen)
            begin
                seen_reg <= '0;
            end
            if (cmd.write_rec)
            begin
                valid_reg[sel_reg] <= 1'b1;
                if (item_reg.op == OP_REFRESH)
                begin
                    seen_reg[sel_reg] <= 1'b1;
                end
                else if (!found_reg)
                begin
                    seen_reg[sel_reg] <= 1'b0;
                end
            end
        end
    end

    // Payload flops: item hold, search indexes, result
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item;
            rd_in_range_reg <= (CntW'(item.read_index) < CntW'(TableSize))
                               || (IdxW > SlotW);
            sel_reg <= IdxW'(item.read_index);
        end
        if (cmd.scan_step)
        begin
            if (valid_reg[cur] && ram_q.key == item_reg.peer_key && !found_reg)
                hit_idx_reg <= cur;
            if (!valid_reg[cur] && !free_reg)
                free_idx_reg <= cur;
            if (valid_reg[cur] && ram_q.status == ST_GONE
                && (!gone_reg || ram_q.down <= least_reg))
            begin
                gone_idx_reg <= cur;
                least_reg    <= ram_q.down;
            end
            if (ram_q.status == ST_DROPPED && !drop_reg)
                drop_idx_reg <= cur;
        end
        if (cmd.rd_sel && item_reg.op != OP_READ)
        begin
            sel_reg <= chosen;
        end
        if (cmd.emit_zero)
        begin
            res_reg <= '0;
        end
        else if (cmd.emit)
        begin
            if (item_reg.op == OP_READ)
            begin
                if (rd_in_range_reg && valid_reg[sel_reg])
                begin
                    res_reg.slot_index   <= SlotW'(sel_reg);
                    res_reg.hit          <= 1'b1;
                    res_reg.slot_used    <= 1'b1;
                    res_reg.slot_key     <= ram_q.key;
                    res_reg.peer_state   <= ram_q.status;
                    res_reg.update_count <= ram_q.count;
                    res_reg.alloc_time   <= ram_q.first;
                    res_reg.touch_time   <= ram_q.last;
                    res_reg.down_time    <= ram_q.down;
                end
                // Unwritten slot reads as a cleared record
                else if (rd_in_range_reg)
                begin
                    res_reg.slot_index   <= SlotW'(sel_reg);
                    res_reg.hit          <= 1'b0;
                    res_reg.slot_used    <= 1'b0;
                    res_reg.slot_key     <= '0;
                    res_reg.peer_state   <= ST_ACTIVE;
                    res_reg.update_count <= '0;
                    res_reg.alloc_time   <= '0;
                    res_reg.touch_time   <= '0;
                    res_reg.down_time    <= '0;
                end
                else
                begin
                    res_reg <= '0;
                end
            end
            else
            begin
                res_reg.slot_index   <= SlotW'(sel_reg);
                res_reg.hit          <= found_reg;
                res_reg.slot_used    <= 1'b1;
                res_reg.slot_key     <= upd.key;
                res_reg.peer_state   <= upd.status;
                res_reg.update_count <= upd.count;
                res_reg.alloc_time   <= upd.first;
                res_reg.touch_time   <= upd.last;
                res_reg.down_time    <= upd.down;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;
endmodule

FILE: rtl/peer_table_with_eviction_unit.sv
// Top level: peer table with lookup, allocation and eviction
//
//  channel | signals              | handshake
//  --------+----------------------+--------------------------------
//  item    | start, busy, item    | taken when start && !busy
//  result  | done, result         | one-cycle strobe, no back-pressure
//
// For a lookup or update, one slot of the record RAM is read per cycle
// during the scan, then the chosen slot is read, written back and shown;
// interest or down for an unknown peer skips the write. End of snapshot
// reads each slot and marks it in the next cycle. Reset clears the valid
// and seen marks at once; no clearing pass. Results leave as a strobe that
// cannot stall.
module peer_table_with_eviction_unit import ptev_pkg::*; #(
    parameter int TableSize = TableSizeDefault
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result
);
    cmd_t  cmd;
    stat_t stat;

    ptev_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .op   (item.op),
        .stat (stat),
        .busy (busy),
        .cmd  (cmd)
    );

    ptev_dp #(.TableSize(TableSize)) u_dp (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .item (item),
        .cmd  (cmd),
        .stat (stat),
        .done (done),
        .res  (result)
    );
endmodule

FILE: rtl/ptev_checker.sv
// Port-level checker for the peer table block, bound to the top level
module ptev_checker import ptev_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input item_t   item,
    input logic    busy,
    input logic    done,
    input result_t result
);
    // An accepted beat makes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");

    // A result strobe lasts one cycle
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");

    // A result comes only after work, and the block is idle then
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy)) else $error("stray result");

    // An unused slot reports no hit, a zero key and a zero update count
    a_unused: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.slot_used |-> !result.hit && result.slot_key == '0
        && result.update_count == '0) else $error("unused slot with data");
endmodule

bind peer_table_with_eviction_unit ptev_checker u_ptev_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .item(item),
    .busy(busy), .done(done), .result(result)
);

FILE: tb/tb_peer_table_with_eviction_unit.sv
// Testbench for the peer table block: directed and randomized event stream checked against a table predictor
`timescale 1ns / 100ps

module tb_peer_table_with_eviction_unit;
    import ptev_pkg::*;

    localparam int NumSlots = 64;
    localparam int IdleLimit = 5000;

    logic    clk;
    logic    rst_n;
    logic    start;
    item_t   item;
    logic    busy;
    logic    done;
    result_t result;

    peer_table_with_eviction_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // Predicted table contents
    bit        tbl_valid [NumSlots];
    bit [31:0] tbl_key   [NumSlots];
    bit [1:0]  tbl_state [NumSlots];
    bit        tbl_seen  [NumSlots];
    bit [31:0] tbl_count [NumSlots];
    bit [47:0] tbl_first [NumSlots];
    bit [47:0] tbl_last  [NumSlots];
    bit [47:0] tbl_down  [NumSlots];

    item_t   pending_items [$];
    bit      pause_before  [$];
    result_t expected_results [$];
    bit      beat_taken;
    int      gap_left;
    int      idle_cycles;
    int      errors;

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int find_peer(bit [31:0] key);
        for (int i = 0; i < NumSlots; i++)
        begin
            if (tbl_valid[i] && tbl_key[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic int choose_victim();
        int        v;
        bit [47:0] least;
        v = -1;
        least = '1;
        for (int i = 0; i < NumSlots; i++)
        begin
            if (!tbl_valid[i]) return i;
        end
        // oldest gone entry, last one wins ties
        for (int i = 0; i < NumSlots; i++)
        begin
            if (tbl_state[i] == ST_GONE && tbl_down[i] <= least)
            begin
                least = tbl_down[i];
                v = i;
            end
        end
        if (v >= 0) return v;
        for (int i = 0; i < NumSlots; i++)
        begin
            if (tbl_state[i] == ST_DROPPED) return i;
        end
        return 0;
    endfunction

    function automatic int claim_slot(bit [31:0] key, bit [47:0] now, output bit found);
        int s;
        s = find_peer(key);
        found = (s >= 0);
        if (found) return s;
        s = choose_victim();
        tbl_valid[s] = 1'b1;
        tbl_key[s]   = key;
        tbl_state[s] = ST_ACTIVE;
        tbl_seen[s]  = 1'b0;
        tbl_count[s] = '0;
        tbl_first[s] = now;
        tbl_last[s]  = '0;
        tbl_down[s]  = '0;
        return s;
    endfunction

    function automatic result_t slot_view(int s, bit hit);
        result_t r;
        r.slot_index   = s[5:0];
        r.hit          = hit;
        r.slot_used    = tbl_valid[s];
        r.slot_key     = tbl_key[s];
        r.peer_state   = tbl_state[s];
        r.update_count = tbl_count[s];
        r.alloc_time   = tbl_first[s];
        r.touch_time   = tbl_last[s];
        r.down_time    = tbl_down[s];
        return r;
    endfunction

    // Apply one event to the predicted table and return the slot it shows
    function automatic result_t apply_peer_event(item_t it);
        result_t r;
        int      s;
        bit      found;
        r = '0;
        case (op_t'(it.op))
            OP_UP:
            begin
                s = claim_slot(it.peer_key, it.now_ms, found);
                tbl_last[s] = it.now_ms;
                r = slot_view(s, found);
            end
            OP_INTEREST:
            begin
                s = find_peer(it.peer_key);
                if (s >= 0)
                begin
                    tbl_count[s] = tbl_count[s] + 1;
                    tbl_last[s] = it.now_ms;
                    r = slot_view(s, 1'b1);
                end
            end
            OP_DOWN:
            begin
                s = find_peer(it.peer_key);
                if (s >= 0)
                begin
                    tbl_down[s] = it.now_ms;
                    r = slot_view(s, 1'b1);
                end
            end
            OP_BEGIN:
            begin
                for (int i = 0; i < NumSlots; i++) tbl_seen[i] = 1'b0;
            end
            OP_REFRESH:
            begin
                s = claim_slot(it.peer_key, it.now_ms, found);
                tbl_seen[s] = 1'b1;
                tbl_state[s] = it.peer_is_dropped ? ST_DROPPED : ST_ACTIVE;
                r = slot_view(s, found);
            end
            OP_END:
            begin
                for (int i = 0; i < NumSlots; i++)
                begin
                    if (tbl_valid[i] && !tbl_seen[i] && tbl_state[i] != ST_GONE)
                    begin
                        tbl_state[i] = ST_GONE;
                        if (tbl_down[i] == 0) tbl_down[i] = it.now_ms;
                    end
                end
            end
            OP_READ:
            begin
                r = slot_view(int'(it.read_index), tbl_valid[it.read_index]);
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_field(string name, bit [63:0] exp_v, bit [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic compare_result(result_t exp_r, result_t act_r);
        report_field("slot_index", exp_r.slot_index, act_r.slot_index);
        report_field("hit", exp_r.hit, act_r.hit);
        report_field("slot_used", exp_r.slot_used, act_r.slot_used);
        report_field("slot_key", exp_r.slot_key, act_r.slot_key);
        report_field("peer_state", exp_r.peer_state, act_r.peer_state);
        report_field("update_count", exp_r.update_count, act_r.update_count);
        report_field("alloc_time", exp_r.alloc_time, act_r.alloc_time);
        report_field("touch_time", exp_r.touch_time, act_r.touch_time);
        report_field("down_time", exp_r.down_time, act_r.down_time);
    endtask

    // Monitor: check result beats, predict accepted item beats, watch for a hang
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_taken <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0h", $time, result);
                    errors++;
                end
                else
                begin
                    compare_result(expected_results.pop_front(), result);
                end
            end
            if (start && !busy) expected_results.push_back(apply_peer_event(item));
            beat_taken <= start && !busy;
            if (done || (start && !busy)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Driver: present queued items, with random gaps and drain pauses
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
            gap_left <= 0;
        end
        else if (!start || beat_taken)
        begin
            if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() != 0 &&
                     !(pause_before[0] && (expected_results.size() != 0 || busy)))
            begin
                item <= pending_items.pop_front();
                void'(pause_before.pop_front());
                start <= 1'b1;
                if ($urandom_range(0, 99) < 40) gap_left <= 0;
                else if ($urandom_range(0, 99) < 92) gap_left <= $urandom_range(1, 4);
                else gap_left <= $urandom_range(20, 150);
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    bit [47:0] clock_ms;

    task automatic queue_item(op_t op, bit [31:0] key, bit [47:0] now, bit dropped,
                              bit [5:0] idx, bit pause);
        item_t it;
        it.op = op;
        it.peer_key = key;
        it.now_ms = now;
        it.peer_is_dropped = dropped;
        it.read_index = idx;
        pending_items.push_back(it);
        pause_before.push_back(pause);
    endtask

    // Key from a pool a little larger than the table, or fully random
    function automatic bit [31:0] pick_key();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return 32'h1000 + $urandom_range(0, 79);
    endfunction

    // Time mostly advancing, sometimes extreme, sometimes repeated to force ties
    function automatic bit [47:0] pick_time();
        int k;
        k = $urandom_range(0, 99);
        if (k < 5) return '0;
        if (k < 10) return '1;
        if (k < 15) return 48'({$urandom(), $urandom()});
        if (k < 30) return 48'd1000;
        clock_ms = clock_ms + $urandom_range(1, 50);
        return clock_ms;
    endfunction

    initial
    begin
        int n;
        op_t op;
        errors = 0;
        clock_ms = 48'd5000;
        rst_n = 1'b0;

        // Directed part
        queue_item(OP_UP, 32'h0, 48'd1, 1'b0, 6'd0, 1'b0);
        queue_item(OP_UP, 32'hFFFF_FFFF, '1, 1'b0, 6'd0, 1'b0);
        queue_item(OP_UP, 32'hFFFF_FFFF, 48'd7, 1'b0, 6'd0, 1'b0);
        queue_item(OP_INTEREST, 32'h0, 48'hAAAA_5555_AAAA, 1'b0, 6'd0, 1'b0);
        queue_item(OP_INTEREST, 32'h1234_5678, 48'd9, 1'b0, 6'd0, 1'b0);
        queue_item(OP_DOWN, 32'h1234_5678, 48'd9, 1'b0, 6'd0, 1'b0);
        queue_item(OP_DOWN, 32'h0, 48'd0, 1'b0, 6'd0, 1'b0);
        queue_item(OP_DOWN, 32'hFFFF_FFFF, '1, 1'b0, 6'd0, 1'b0);
        queue_item(OP_BEGIN, 32'h0, 48'd10, 1'b0, 6'd0, 1'b0);
        queue_item(OP_REFRESH, 32'h0, 48'd11, 1'b1, 6'd0, 1'b0);
        queue_item(OP_REFRESH, 32'h5555_AAAA, 48'd12, 1'b0, 6'd0, 1'b0);
        queue_item(OP_END, 32'h0, 48'd13, 1'b0, 6'd0, 1'b0);
        queue_item(OP_READ, 32'h0, 48'd0, 1'b0, 6'd0, 1'b0);
        queue_item(OP_READ, 32'h0, 48'd0, 1'b0, 6'd1, 1'b0);
        queue_item(OP_READ, 32'h0, 48'd0, 1'b0, 6'd63, 1'b0);
        queue_item(OP_NONE, 32'hFFFF_FFFF, '1, 1'b1, 6'd63, 1'b1);
        queue_item(OP_UP, 32'h0, 48'd20, 1'b1, 6'd42, 1'b0);

        // Random part: event bursts and snapshot rounds
        n = pending_items.size();
        while (n < 1450)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                int cnt;
                cnt = $urandom_range(1, 40);
                queue_item(OP_BEGIN, $urandom(), pick_time(), 1'($urandom_range(0, 1)),
                           6'($urandom_range(0, 63)), 1'b0);
                for (int i = 0; i < cnt; i++)
                    queue_item(OP_REFRESH, pick_key(), pick_time(), $urandom_range(0, 3) == 0,
                               6'($urandom_range(0, 63)), 1'b0);
                if ($urandom_range(0, 9) != 0)
                    queue_item(OP_END, $urandom(), pick_time(), 1'($urandom_range(0, 1)),
                               6'($urandom_range(0, 63)), 1'b0);
                n += cnt + 2;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5: op = OP_UP;
                    6, 7, 8, 9:       op = OP_INTEREST;
                    10, 11, 12:       op = OP_DOWN;
                    13, 14:           op = OP_READ;
                    15:               op = OP_NONE;
                    16:               op = OP_BEGIN;
                    17:               op = OP_END;
                    default:          op = OP_REFRESH;
                endcase
                queue_item(op, pick_key(), pick_time(), 1'($urandom_range(0, 1)),
                           6'($urandom_range(0, 63)), $urandom_range(0, 99) == 0);
                n++;
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain and finish
        wait (pending_items.size() == 0 && !start);
        wait (expected_results.size() == 0);
        repeat (150) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
